// ----- rtl/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants of the sorted key table
// Table geometry, item codes and the request/response structs passed between
// the top level and the search/shift engine.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 32;
  localparam int FIELD_W     = 9;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_t;

  typedef enum logic {
    STATUS_DONE = 1'b0,
    STATUS_FULL = 1'b1
  } status_t;

  typedef struct packed {
    kind_t             kind;
    logic [KEY_W-1:0]  key;
  } req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] position;
    logic               found;
    status_t            status;
    logic [FIELD_W-1:0] entries;
  } rsp_t;

  // Keep the low bits of a table index for a result field.
  function automatic logic [FIELD_W-1:0] idx_field(input logic [ADDR_W-1:0] v);
    logic [ADDR_W+FIELD_W-1:0] wide;
    wide = {{FIELD_W{1'b0}}, v};
    return wide[FIELD_W-1:0];
  endfunction

  // Keep the low bits of an entry count for a result field.
  function automatic logic [FIELD_W-1:0] cnt_field(input logic [CNT_W-1:0] v);
    logic [CNT_W+FIELD_W-1:0] wide;
    wide = {{FIELD_W{1'b0}}, v};
    return wide[FIELD_W-1:0];
  endfunction

endpackage

// ----- rtl/sorted_key_table.sv -----
// ----------------------------------------------------------------------------
// sorted_key_table: ascending table of signed 32-bit keys
// Inserts keys in order and looks them up by binary search.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry the key on s_tdata and the item kind on s_tuser
//   (insert or lookup). Each beat yields exactly one output beat with the
//   position, the found flag, the full status and the entry count.
//   One item at a time: s_tready is high only while the engine is idle, and
//   the next beat is taken in the cycle after a result enters the output register.
//   On the way from the taken beat to m_tvalid, each probe of the binary
//   search reads the RAM at the midpoint and then compares (at most 9 probes
//   at 256 entries); a search that ends without a match passes once more
//   through the address state. An insert then moves the (entries - position)
//   upper keys up one place through the single RAM port and writes the new
//   key, a refused insert goes straight to its result, and every result is
//   then loaded into the output register.
//   The output register holds a result while m_tready stalls; the next result
//   waits in the engine until it frees. Reset empties the table at once.
// ----------------------------------------------------------------------------
module sorted_key_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] key
  input  logic        s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [8:0] position, [17:9] entries, [23:18] zero
  output logic [1:0]  m_tuser    // [0] found, [1] status
);
  import skt_pkg::*;

  req_t req;
  rsp_t eng_rsp;
  rsp_t out_rsp;
  logic eng_ready;
  logic eng_valid;
  logic eng_take;
  logic out_valid;

  assign req.kind = kind_t'(s_tuser);
  assign req.key  = s_tdata;

  // Free the output register when it is empty or drains this cycle.
  assign eng_take = !out_valid || m_tready;

  skt_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (s_tvalid && eng_ready),
    .req       (req),
    .ready     (eng_ready),
    .rsp_valid (eng_valid),
    .rsp_ready (eng_take),
    .rsp       (eng_rsp)
  );

  assign s_tready = eng_ready;

  // Output register: load a finished result, hold it while the sink stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eng_take) begin
      out_valid <= eng_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_take && eng_valid) begin
      out_rsp <= eng_rsp;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_rsp.entries, out_rsp.position};
  assign m_tuser  = {out_rsp.status, out_rsp.found};

endmodule

// ----- rtl/skt_engine.sv -----
// ----------------------------------------------------------------------------
// skt_engine: key memory with binary search and insert shift
// Holds the sorted keys in a synchronous RAM, probes it one midpoint at a
// time and moves the upper entries up one place before writing a new key.
// ----------------------------------------------------------------------------
module skt_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  skt_pkg::req_t req,
  output logic          ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output skt_pkg::rsp_t rsp
);
  import skt_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ADDR  = 5'b00010,
    ST_CMP   = 5'b00100,
    ST_SHIFT = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t            state;
  kind_t             kind_q;
  logic [KEY_W-1:0]  key_q;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  lo;
  logic [CNT_W-1:0]  hip1;
  logic [ADDR_W-1:0] mid_q;
  logic [ADDR_W-1:0] pos_q;
  logic [CNT_W-1:0]  sh_cnt;
  logic [ADDR_W-1:0] sh_addr;
  logic              pend;
  logic [ADDR_W-1:0] pend_addr;
  rsp_t              rsp_q;

  logic [KEY_W-1:0]  mem [TABLE_DEPTH];
  logic [KEY_W-1:0]  rd_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              we;
  logic [ADDR_W-1:0] wr_addr;
  logic [KEY_W-1:0]  wr_data;

  logic [CNT_W-1:0]  span;
  logic [CNT_W-1:0]  mid_w;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_p1;
  logic [CNT_W-1:0]  mid_ext;
  logic [CNT_W-1:0]  miss_left;
  logic [CNT_W-1:0]  hit_left;
  logic              probe;
  logic              key_eq;
  logic              key_lt;

  assign span    = hip1 - lo - {{(CNT_W-1){1'b0}}, 1'b1};
  assign mid_w   = lo + (span >> 1);
  assign probe   = (lo < hip1);
  assign cnt_m1  = count - {{(CNT_W-1){1'b0}}, 1'b1};
  assign cnt_p1  = count + {{(CNT_W-1){1'b0}}, 1'b1};
  assign mid_ext = {{(CNT_W-ADDR_W){1'b0}}, mid_q};
  assign miss_left = count - lo;
  assign hit_left  = count - mid_ext;
  assign key_eq  = (rd_data == key_q);
  assign key_lt  = ($signed(rd_data) < $signed(key_q));

  assign ready     = (state == ST_IDLE);
  assign rsp_valid = (state == ST_DONE);
  assign rsp       = rsp_q;

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = mid_w[ADDR_W-1:0];
    we      = 1'b0;
    wr_addr = pend_addr;
    wr_data = rd_data;
    if (state == ST_ADDR) begin
      rd_en = probe;
    end else if (state == ST_SHIFT) begin
      we = pend;
      if (sh_cnt != '0) begin
        rd_en   = 1'b1;
        rd_addr = sh_addr;
      end else if (!pend) begin
        we      = 1'b1;
        wr_addr = pos_q;
        wr_data = key_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            kind_q <= req.kind;
            key_q  <= req.key;
            lo     <= '0;
            hip1   <= count;
            if (req.kind == KIND_INSERT && count == CNT_W'(TABLE_DEPTH)) begin
              rsp_q <= '{position: '0, found: 1'b0, status: STATUS_FULL,
                         entries: cnt_field(count)};
              state <= ST_DONE;
            end else begin
              state <= ST_ADDR;
            end
          end
        end
        ST_ADDR: begin
          if (probe) begin
            mid_q <= mid_w[ADDR_W-1:0];
            state <= ST_CMP;
          end else if (kind_q == KIND_LOOKUP) begin
            rsp_q <= '{position: '0, found: 1'b0, status: STATUS_DONE,
                       entries: cnt_field(count)};
            state <= ST_DONE;
          end else begin
            pos_q   <= lo[ADDR_W-1:0];
            sh_cnt  <= miss_left;
            sh_addr <= cnt_m1[ADDR_W-1:0];
            pend    <= 1'b0;
            state   <= ST_SHIFT;
          end
        end
        ST_CMP: begin
          if (key_eq) begin
            if (kind_q == KIND_LOOKUP) begin
              rsp_q <= '{position: idx_field(mid_q), found: 1'b1,
                         status: STATUS_DONE, entries: cnt_field(count)};
              state <= ST_DONE;
            end else begin
              pos_q   <= mid_q;
              sh_cnt  <= hit_left;
              sh_addr <= cnt_m1[ADDR_W-1:0];
              pend    <= 1'b0;
              state   <= ST_SHIFT;
            end
          end else if (key_lt) begin
            lo    <= mid_ext + {{(CNT_W-1){1'b0}}, 1'b1};
            state <= ST_ADDR;
          end else begin
            hip1  <= mid_ext;
            state <= ST_ADDR;
          end
        end
        ST_SHIFT: begin
          if (sh_cnt != '0) begin
            pend      <= 1'b1;
            pend_addr <= sh_addr + {{(ADDR_W-1){1'b0}}, 1'b1};
            sh_addr   <= sh_addr - {{(ADDR_W-1){1'b0}}, 1'b1};
            sh_cnt    <= sh_cnt - {{(CNT_W-1){1'b0}}, 1'b1};
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              count <= cnt_p1;
              rsp_q <= '{position: idx_field(pos_q), found: 1'b0,
                         status: STATUS_DONE, entries: cnt_field(cnt_p1)};
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (rsp_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
